// ----- rtl/core/tshf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn signal and hazard flasher package
// Mode codes, constants and the structs passed between the core's modules.
// ----------------------------------------------------------------------------
package tshf_pkg;

  localparam int HALF_PERIOD_W = 16;
  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd333;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_HAZARD = 3'd2,
    MODE_LEFT   = 3'd3,
    MODE_RIGHT  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2,
    TURN_BOTH  = 2'd3
  } turn_t;

  // What the mode machine tells the flasher for the current tick.
  typedef struct packed {
    logic  entry;
    mode_t mode;
  } tshf_cmd_t;

  typedef struct packed {
    logic left;
    logic right;
  } tshf_lamps_t;

  typedef struct packed {
    mode_t       mode;
    tshf_lamps_t lamps;
  } tshf_result_t;

endpackage

// ----- rtl/core/turn_signal_hazard_flasher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn signal and hazard flasher core
// Drives the left and right indicator lamps from timer tick requests.
// ----------------------------------------------------------------------------
// Each request on the in_ stream is one timer tick with the ignition, hazard
// switch and turn stalk inputs. Every tick produces exactly one result on the
// out_ stream with both lamp drives and the mode after that tick.
// The mode machine and flasher state update at the accepting edge; the result
// shows on out_tvalid in the next cycle. While the receiver takes each result,
// one tick is accepted every cycle, so the block sustains one request per clock,
// limited only by the single output register. When the receiver stalls, the
// held result stays on out_tdata and in_tready drops until it is taken; a new
// request can enter in the cycle the held result leaves.
// The cfg_ port writes half_period (ticks between lamp toggles); it is always
// ready and should be written only while no tick is in flight.
// Synchronous reset clears the output register, sets the off mode with its
// entry action pending, turns both lamps off and loads half_period with 333.
// ----------------------------------------------------------------------------
module turn_signal_hazard_flasher_core #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] ignition, [1] hazard_switch, [3:2] turn_request, [7:4] zero
  input  logic [tshf_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] left_lamp, [1] right_lamp, [4:2] mode, [7:5] zero
  output logic [tshf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tshf_pkg::HALF_PERIOD_W-1:0]  cfg_data
);
  import tshf_pkg::*;

  logic [HALF_PERIOD_W-1:0] half_period_r;
  logic                     step;
  tshf_cmd_t                cmd;
  mode_t                    mode_nxt;
  tshf_lamps_t              lamps_nxt;
  tshf_result_t             result;
  tshf_result_t             out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_valid) begin
      half_period_r <= cfg_data;
    end
  end

  assign step = in_tvalid && in_tready;

  tshf_mode_fsm u_mode_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .ignition      (in_tdata[0]),
    .hazard_switch (in_tdata[1]),
    .turn_request  (in_tdata[3:2]),
    .cmd           (cmd),
    .mode_nxt      (mode_nxt)
  );

  tshf_flasher #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_flasher (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .cmd         (cmd),
    .half_period (half_period_r),
    .lamps_nxt   (lamps_nxt)
  );

  assign result.mode  = mode_nxt;
  assign result.lamps = lamps_nxt;

  tshf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .result     (result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {3'b000, out_result.mode, out_result.lamps.right,
                      out_result.lamps.left};

endmodule

// ----- rtl/core/tshf_mode_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flasher mode state machine
// Holds the mode and the entry flag; at most one transition per tick.
// ----------------------------------------------------------------------------
module tshf_mode_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               ignition,
  input  logic               hazard_switch,
  input  logic [1:0]         turn_request,
  output tshf_pkg::tshf_cmd_t cmd,
  output tshf_pkg::mode_t    mode_nxt
);
  import tshf_pkg::*;

  mode_t mode_r;
  logic  entry_r;
  logic  entry_nxt;
  mode_t mode_cur;
  mode_t mode_trans;
  turn_t turn;

  assign turn = turn_t'(turn_request);

  // Codes outside the five modes are treated as the off mode.
  always_comb begin
    case (mode_r)
      MODE_OFF, MODE_ON, MODE_HAZARD, MODE_LEFT, MODE_RIGHT: mode_cur = mode_r;
      default: mode_cur = MODE_OFF;
    endcase
  end

  assign cmd.entry = entry_r;
  assign cmd.mode  = mode_cur;

  always_comb begin
    mode_trans = mode_cur;
    case (mode_cur)
      MODE_ON: begin
        if (hazard_switch) mode_trans = MODE_HAZARD;
        else if (!ignition) mode_trans = MODE_OFF;
        else if (turn == TURN_LEFT) mode_trans = MODE_LEFT;
        else if (turn == TURN_RIGHT) mode_trans = MODE_RIGHT;
      end
      MODE_HAZARD: begin
        if (!hazard_switch) mode_trans = MODE_OFF;
      end
      MODE_LEFT: begin
        if (hazard_switch) mode_trans = MODE_HAZARD;
        else if (!ignition) mode_trans = MODE_OFF;
        else if (turn == TURN_RIGHT) mode_trans = MODE_RIGHT;
        else if (turn == TURN_NONE) mode_trans = MODE_OFF;
      end
      MODE_RIGHT: begin
        if (hazard_switch) mode_trans = MODE_HAZARD;
        else if (!ignition) mode_trans = MODE_OFF;
        else if (turn == TURN_LEFT) mode_trans = MODE_LEFT;
        else if (turn == TURN_NONE) mode_trans = MODE_OFF;
      end
      default: begin
        if (hazard_switch) mode_trans = MODE_HAZARD;
        else if (ignition) mode_trans = MODE_ON;
        else mode_trans = MODE_OFF;
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_cur;
    entry_nxt = entry_r;
    if (entry_r) begin
      entry_nxt = 1'b0;
    end else if (mode_trans != mode_cur) begin
      mode_nxt  = mode_trans;
      entry_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      entry_r <= 1'b1;
    end else if (step) begin
      mode_r  <= mode_nxt;
      entry_r <= entry_nxt;
    end
  end

endmodule

// ----- rtl/core/tshf_flasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lamp flasher
// Lamp state, running flags and the shared half-period tick counter.
// ----------------------------------------------------------------------------
module tshf_flasher #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  tshf_pkg::tshf_cmd_t                  cmd,
  input  logic [tshf_pkg::HALF_PERIOD_W-1:0]   half_period,
  output tshf_pkg::tshf_lamps_t                lamps_nxt
);
  import tshf_pkg::*;

  localparam int CMP_W = (COUNTER_BITS + 1 > HALF_PERIOD_W) ? COUNTER_BITS + 1 : HALF_PERIOD_W;

  tshf_lamps_t             lit_r;
  tshf_lamps_t             flash_r;
  tshf_lamps_t             flash_nxt;
  logic [COUNTER_BITS-1:0] cnt_r;
  logic [COUNTER_BITS-1:0] cnt_nxt;
  logic [COUNTER_BITS:0]   cnt_inc;
  logic [CMP_W-1:0]        inc_ext;
  logic [CMP_W-1:0]        half_ext;
  logic                    period_done;

  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign inc_ext  = CMP_W'(cnt_inc);
  assign half_ext = CMP_W'(half_period);
  // A counter wrap also ends the period when half_period is out of its reach.
  assign period_done = cnt_inc[COUNTER_BITS] || (inc_ext >= half_ext);

  always_comb begin
    lamps_nxt = lit_r;
    flash_nxt = flash_r;
    cnt_nxt   = cnt_r;
    if (cmd.entry) begin
      flash_nxt = '0;
      case (cmd.mode)
        MODE_HAZARD: begin
          lamps_nxt = '{left: 1'b1, right: 1'b1};
          flash_nxt = '{left: 1'b1, right: 1'b1};
          cnt_nxt   = '0;
        end
        MODE_LEFT: begin
          lamps_nxt.right = 1'b0;
          lamps_nxt.left  = ~lit_r.left;
          flash_nxt.left  = 1'b1;
          cnt_nxt         = '0;
        end
        MODE_RIGHT: begin
          lamps_nxt.left  = 1'b0;
          lamps_nxt.right = ~lit_r.right;
          flash_nxt.right = 1'b1;
          cnt_nxt         = '0;
        end
        default: begin
          lamps_nxt = '0;
        end
      endcase
    end else if (flash_r.left || flash_r.right) begin
      if (period_done) begin
        cnt_nxt         = '0;
        lamps_nxt.left  = lit_r.left ^ flash_r.left;
        lamps_nxt.right = lit_r.right ^ flash_r.right;
      end else begin
        cnt_nxt = cnt_inc[COUNTER_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r   <= '0;
      flash_r <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      lit_r   <= lamps_nxt;
      flash_r <= flash_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/tshf_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result for the output channel and opens the input when free.
// ----------------------------------------------------------------------------
module tshf_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tshf_pkg::tshf_result_t result,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tshf_pkg::tshf_result_t out_result
);
  import tshf_pkg::*;

  logic         valid_r;
  tshf_result_t result_r;

  // A new request may enter while the held result leaves in the same cycle.
  assign in_ready   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result_r <= result;
    end
  end

endmodule

// ----- rtl/core/tshf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flasher core port checker
// Watches the top level's streams for latency, reset and stall behavior.
// ----------------------------------------------------------------------------
module tshf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tshf_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tshf_pkg::*;

  // Every accepted tick shows its result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result in the next cycle");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With nothing held, the core must take a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready while output register is empty");

  // A stalled result keeps its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind turn_signal_hazard_flasher_core tshf_checker u_tshf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
